// ----- src/rc4s_pkg.sv -----
// Shared types and constants for the RC4 stream cipher block.
package rc4s_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned KIDX_W        = 4;
  localparam int unsigned DROP_W        = 11;
  localparam int unsigned CFG_IDX_W     = 8;

  localparam logic [LEN_W-1:0]  MAX_KEY_BYTES = 5'd16;
  localparam logic [DROP_W-1:0] DROP_LIMIT    = 11'd1024;
  localparam logic [ADDR_W-1:0] LAST_ENTRY    = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_COUNT = 8'd3;

  localparam logic [LEN_W-1:0]  KEY_BYTES_RST  = 5'd16;
  localparam logic [DROP_W-1:0] DROP_COUNT_RST = 11'd256;

  typedef struct packed {
    logic [KEY_W-1:0]  key_low;
    logic [KEY_W-1:0]  key_high;
    logic [LEN_W-1:0]  key_bytes;
    logic [DROP_W-1:0] drop_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_KRD_N,
    ST_KRD_J,
    ST_KWR_N,
    ST_KWR_J,
    ST_GRD_I,
    ST_GRD_J,
    ST_GSWAP,
    ST_GFIN,
    ST_RESP
  } state_t;

endpackage

// ----- src/rc4s_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module rc4s_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rc4s_cfg.sv -----
// Configuration register file for the RC4 stream cipher block.
module rc4s_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rc4s_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4s_pkg::KEY_W-1:0]      cfg_data,
  output rc4s_pkg::cfg_t                  cfg
);

  rc4s_pkg::cfg_t cfg_r;
  rc4s_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rc4s_pkg::REG_KEY_LOW:    cfg_nxt.key_low    = cfg_data;
        rc4s_pkg::REG_KEY_HIGH:   cfg_nxt.key_high   = cfg_data;
        rc4s_pkg::REG_KEY_BYTES:  cfg_nxt.key_bytes  = cfg_data[rc4s_pkg::LEN_W-1:0];
        rc4s_pkg::REG_DROP_COUNT: cfg_nxt.drop_count = cfg_data[rc4s_pkg::DROP_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_low    <= '0;
      cfg_r.key_high   <= '0;
      cfg_r.key_bytes  <= rc4s_pkg::KEY_BYTES_RST;
      cfg_r.drop_count <= rc4s_pkg::DROP_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/rc4s_ctrl.sv -----
// Sequencer for clearing, key scheduling, keystream generation and result delivery.
module rc4s_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rc4s_pkg::cfg_t                cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rc4s_pkg::BYTE_W-1:0]   in_tdata,
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rc4s_pkg::BYTE_W-1:0]   out_tdata,
  output logic [0:0]                    out_tuser,
  output logic                          ram_we,
  output logic [rc4s_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [rc4s_pkg::BYTE_W-1:0]   ram_wdata,
  output logic [rc4s_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [rc4s_pkg::BYTE_W-1:0]   ram_rdata
);

  rc4s_pkg::state_t state_r, state_nxt;

  logic [rc4s_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [rc4s_pkg::ADDR_W-1:0] i_r, i_nxt;
  logic [rc4s_pkg::ADDR_W-1:0] j_r, j_nxt;
  logic [rc4s_pkg::ADDR_W-1:0] t_r, t_nxt;
  logic [rc4s_pkg::BYTE_W-1:0] si_r, si_nxt;
  logic [rc4s_pkg::BYTE_W-1:0] sj_r, sj_nxt;
  logic [rc4s_pkg::KIDX_W-1:0] k_r, k_nxt;
  logic [rc4s_pkg::DROP_W-1:0] drop_r, drop_nxt;
  logic                        drop_mode_r, drop_mode_nxt;
  logic [rc4s_pkg::BYTE_W-1:0] din_r, din_nxt;
  logic [rc4s_pkg::BYTE_W-1:0] res_data_r, res_data_nxt;
  logic                        res_done_r, res_done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rc4s_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic                        out_done_r, out_done_nxt;

  logic [2*rc4s_pkg::KEY_W-1:0] key_vec;
  logic [rc4s_pkg::BYTE_W-1:0]  key_b;
  logic [rc4s_pkg::LEN_W-1:0]   len_eff;
  logic [rc4s_pkg::DROP_W-1:0]  drops_eff;
  logic [rc4s_pkg::ADDR_W-1:0]  ks;
  logic                         slot_free;
  logic                         fin_go;
  logic [rc4s_pkg::BYTE_W-1:0]  fin_data;
  logic                         fin_done;

  assign key_vec = {cfg.key_high, cfg.key_low};
  assign key_b   = key_vec[{k_r, 3'b000} +: rc4s_pkg::BYTE_W];

  assign len_eff = (cfg.key_bytes == '0) ? 5'd1 :
                   (cfg.key_bytes > rc4s_pkg::MAX_KEY_BYTES) ? rc4s_pkg::MAX_KEY_BYTES :
                   cfg.key_bytes;
  assign drops_eff = (cfg.drop_count > rc4s_pkg::DROP_LIMIT) ? rc4s_pkg::DROP_LIMIT :
                     cfg.drop_count;

  // The second swap write lands in the same cycle as the output read returns.
  assign ks = (t_r == j_r) ? si_r : (t_r == i_r) ? sj_r : ram_rdata;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    k_nxt         = k_r;
    drop_nxt      = drop_r;
    drop_mode_nxt = drop_mode_r;
    din_nxt       = din_r;
    res_data_nxt  = res_data_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_done_nxt  = out_done_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_raddr     = cnt_r;
    fin_go        = 1'b0;
    fin_data      = '0;
    fin_done      = 1'b0;

    unique case (state_r)
      rc4s_pkg::ST_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == rc4s_pkg::LAST_ENTRY) begin
          state_nxt = rc4s_pkg::ST_IDLE;
        end
      end
      rc4s_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          din_nxt = in_tdata;
          if (in_tuser[0]) begin
            cnt_nxt   = '0;
            state_nxt = rc4s_pkg::ST_FILL;
          end else begin
            drop_mode_nxt = 1'b0;
            state_nxt     = rc4s_pkg::ST_GRD_I;
          end
        end
      end
      rc4s_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = cnt_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == rc4s_pkg::LAST_ENTRY) begin
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = rc4s_pkg::ST_KRD_N;
        end
      end
      rc4s_pkg::ST_KRD_N: begin
        ram_raddr = cnt_r;
        state_nxt = rc4s_pkg::ST_KRD_J;
      end
      rc4s_pkg::ST_KRD_J: begin
        si_nxt    = ram_rdata;
        j_nxt     = j_r + key_b + ram_rdata;
        ram_raddr = j_nxt;
        state_nxt = rc4s_pkg::ST_KWR_N;
      end
      rc4s_pkg::ST_KWR_N: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = ram_rdata;
        state_nxt = rc4s_pkg::ST_KWR_J;
      end
      rc4s_pkg::ST_KWR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = si_r;
        cnt_nxt   = cnt_r + 8'd1;
        if ({1'b0, k_r} + 5'd1 >= len_eff) begin
          k_nxt = '0;
        end else begin
          k_nxt = k_r + 4'd1;
        end
        if (cnt_r == rc4s_pkg::LAST_ENTRY) begin
          i_nxt         = '0;
          j_nxt         = '0;
          drop_nxt      = drops_eff;
          drop_mode_nxt = 1'b1;
          if (drops_eff == '0) begin
            fin_go   = 1'b1;
            fin_done = 1'b1;
          end else begin
            state_nxt = rc4s_pkg::ST_GRD_I;
          end
        end else begin
          state_nxt = rc4s_pkg::ST_KRD_N;
        end
      end
      rc4s_pkg::ST_GRD_I: begin
        i_nxt     = i_r + 8'd1;
        ram_raddr = i_nxt;
        state_nxt = rc4s_pkg::ST_GRD_J;
      end
      rc4s_pkg::ST_GRD_J: begin
        si_nxt    = ram_rdata;
        j_nxt     = j_r + ram_rdata;
        ram_raddr = j_nxt;
        state_nxt = rc4s_pkg::ST_GSWAP;
      end
      rc4s_pkg::ST_GSWAP: begin
        sj_nxt    = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
        t_nxt     = si_r + ram_rdata;
        ram_raddr = t_nxt;
        state_nxt = rc4s_pkg::ST_GFIN;
      end
      rc4s_pkg::ST_GFIN: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = si_r;
        if (drop_mode_r) begin
          drop_nxt = drop_r - 11'd1;
          if (drop_r == 11'd1) begin
            fin_go   = 1'b1;
            fin_done = 1'b1;
          end else begin
            state_nxt = rc4s_pkg::ST_GRD_I;
          end
        end else begin
          fin_go   = 1'b1;
          fin_data = din_r ^ ks;
        end
      end
      rc4s_pkg::ST_RESP: begin
        fin_go   = 1'b1;
        fin_data = res_data_r;
        fin_done = res_done_r;
      end
      default: state_nxt = rc4s_pkg::ST_IDLE;
    endcase

    if (fin_go) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fin_data;
        out_done_nxt  = fin_done;
        state_nxt     = rc4s_pkg::ST_IDLE;
      end else begin
        res_data_nxt = fin_data;
        res_done_nxt = fin_done;
        state_nxt    = rc4s_pkg::ST_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4s_pkg::ST_CLEAR;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      drop_r      <= '0;
      drop_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      drop_r      <= drop_nxt;
      drop_mode_r <= drop_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    din_r      <= din_nxt;
    res_data_r <= res_data_nxt;
    res_done_r <= res_done_nxt;
    out_data_r <= out_data_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_done_r;

endmodule

// ----- src/rc4_stream_cipher_top.sv -----
// RC4 stream cipher with keystream drop after rekey: top level.
//
// The input stream carries one item per byte: tuser bit 0 selects rekey (1) or data (0),
// tdata holds the byte. Each item yields one result: tdata holds the byte XORed with the
// keystream byte (zero on rekey) and tuser bit 0 marks a rekey answer.
// The configuration channel writes the key words, the key length and the drop count;
// it is always ready; the user must write it only while the block is idle (unenforced).
// The permutation lives in one 256 x 8 RAM with one write and one read port, so every
// step is a sequence of dependent RAM accesses.
// A data item runs through the chain read i, read j, swap and output read through the
// single read port, and its result is registered in the output register; the block
// takes no new item until it is back in idle.
// A rekey item loads the identity permutation, runs key scheduling over every entry,
// then discards drop count keystream bytes, clamped to 1024; its result is registered
// in the output register after the last of these, and the block then returns to idle.
// After reset the block clears every RAM entry to zeros with in_tready low.
// One item is in work at a time. A result that the receiver does not take stays in the
// output register; a finished result behind it waits in a holding register until then.
module rc4_stream_cipher_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_in
  input  logic [0:0]                      in_tuser,   // [0] action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] data_out
  output logic [0:0]                      out_tuser,  // [0] rekey_done
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc4s_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4s_pkg::KEY_W-1:0]      cfg_data
);

  rc4s_pkg::cfg_t                cfg;
  logic                          ram_we;
  logic [rc4s_pkg::ADDR_W-1:0]   ram_waddr;
  logic [rc4s_pkg::BYTE_W-1:0]   ram_wdata;
  logic [rc4s_pkg::ADDR_W-1:0]   ram_raddr;
  logic [rc4s_pkg::BYTE_W-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;

  rc4s_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rc4s_ram #(
    .WIDTH (rc4s_pkg::BYTE_W),
    .DEPTH (rc4s_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rc4s_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

endmodule

// ----- src/rc4s_checker.sv -----
// Port-level assertions for the RC4 stream cipher top level, with its bind.
module rc4s_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [7:0]                      out_tdata,
  input logic [0:0]                      out_tuser
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Output item dropped while stalled.");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("Output item changed while stalled.");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("Block not busy and empty after reset.");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second item accepted while one is in work.");

  a_rekey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'd0)
    else $error("Rekey answer carries nonzero data.");

endmodule

bind rc4_stream_cipher_top rc4s_checker u_rc4s_checker (.*);
